// ----- rtl/wrh_pkg.sv -----
// ----------------------------------------------------------------------------
// wrh_pkg: shared types and constants for the water ripple height field
// Field geometry defaults, command codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package wrh_pkg;

  localparam int DEF_FIELD_WIDTH  = 128;
  localparam int DEF_FIELD_HEIGHT = 128;
  localparam logic [3:0] DAMP_RESET = 4'd5;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_BLOB = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  // datapath operations issued by the controller
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_RIP   = 3'd3;
  localparam logic [2:0] OP_BLOB  = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic       page;      // write page for ripple/blob, read page for read
    logic       first;     // first cycle of an operation: load addresses
  } wrh_cmd_t;

  typedef struct packed {
    logic done;            // last memory write (or the read) of the operation issued
  } wrh_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'sh7fff;
    if (v < -21'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ----- rtl/wrh_datapath.sv -----
// ----------------------------------------------------------------------------
// wrh_datapath: height memories, address walkers and ripple arithmetic
// One memory per page holds the field; ripple reads the eight old page
// neighbours and the own new page value serially, one read per cycle.
// ----------------------------------------------------------------------------
module wrh_datapath import wrh_pkg::*; #(
  parameter int FIELD_WIDTH  = DEF_FIELD_WIDTH,
  parameter int FIELD_HEIGHT = DEF_FIELD_HEIGHT,
  localparam int CELLS = FIELD_WIDTH * FIELD_HEIGHT,
  localparam int AW    = $clog2(CELLS),
  localparam int XW    = $clog2(FIELD_WIDTH),
  localparam int YW    = $clog2(FIELD_HEIGHT)
) (
  input  logic                clk,
  input  logic                rst,
  input  wrh_cmd_t            cmd,
  output wrh_stat_t           stat,
  input  logic [3:0]          damp,
  input  logic signed [10:0]  pos_x,
  input  logic signed [10:0]  pos_y,
  input  logic [3:0]          blob_radius,
  input  logic signed [15:0]  blob_height,
  input  logic [13:0]         read_index,
  output logic signed [15:0]  rd_value
);

  // Memories: one per page. Sequential ops, one access of each kind per cycle.
  logic signed [15:0] mem_a [CELLS];
  logic signed [15:0] mem_b [CELLS];

  logic          we;
  logic          wpage;
  logic [AW-1:0] waddr;
  logic signed [15:0] wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  logic signed [15:0] q_a, q_b;

  always_ff @(posedge clk) begin
    if (we && !wpage) mem_a[waddr] <= wdata;
    if (we && wpage)  mem_b[waddr] <= wdata;
    q_a <= mem_a[raddr_a];
    q_b <= mem_b[raddr_b];
  end

  // Walker: phase counter steps through the 9 reads and one write per pixel.
  // Ripple: phases 0..8 read the eight old neighbours plus the own new value.
  // Blob: phase 0 reads, phase 2 writes.
  logic [3:0]   ph;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic signed [11:0] bx, by;     // blob walk absolute coordinates
  logic signed [4:0]  dx, dy;
  logic signed [20:0] acc;
  logic signed [15:0] own;
  logic          pg;
  logic [2:0]    op;

  // request payload, held for the whole operation
  logic signed [10:0] org_x;
  logic [3:0]         rad;
  logic signed [15:0] amt;
  logic [13:0]        ridx;

  localparam logic [XW-1:0] XLAST = XW'(FIELD_WIDTH - 2);
  localparam logic [YW-1:0] YLAST = YW'(FIELD_HEIGHT - 2);

  // neighbour offset per phase
  logic signed [1:0] ox, oy;
  always_comb begin
    ox = 2'sd0; oy = 2'sd0;
    case (ph)
      4'd0: begin ox = -2'sd1; oy = -2'sd1; end
      4'd1: begin ox =  2'sd0; oy = -2'sd1; end
      4'd2: begin ox =  2'sd1; oy = -2'sd1; end
      4'd3: begin ox = -2'sd1; oy =  2'sd0; end
      4'd4: begin ox =  2'sd1; oy =  2'sd0; end
      4'd5: begin ox = -2'sd1; oy =  2'sd1; end
      4'd6: begin ox =  2'sd0; oy =  2'sd1; end
      4'd7: begin ox =  2'sd1; oy =  2'sd1; end
      default: begin ox = 2'sd0; oy = 2'sd0; end
    endcase
  end

  logic [AW-1:0] pix;
  logic [AW-1:0] nb;
  assign pix = AW'(cy) * AW'(FIELD_WIDTH) + AW'(cx);
  assign nb  = AW'($signed({1'b0, pix}) + $signed(AW'(oy)) * $signed({1'b0, AW'(FIELD_WIDTH)})
               + $signed(AW'(ox)));

  logic [AW-1:0] baddr;
  logic          bin;
  logic [8:0]    rr;
  assign rr = 9'(rad) * 9'(rad);
  assign baddr = AW'(by[YW:0]) * AW'(FIELD_WIDTH) + AW'(bx[XW:0]);
  always_comb begin
    bin = (by >= 12'sd1) && (by <= 12'(FIELD_HEIGHT - 2)) &&
          (bx >= 12'sd1) && (bx <= 12'(FIELD_WIDTH - 2)) &&
          ($signed(10'(dx * dx)) + $signed(10'(dy * dy)) < $signed({1'b0, rr}));
  end

  logic signed [15:0] oldq, newq;
  assign oldq = pg ? q_a : q_b;
  assign newq = pg ? q_b : q_a;

  logic signed [20:0] h, hd;
  assign h  = (acc >>> 2) - 21'(own);
  assign hd = h - (h >>> damp);

  logic [CELLS > 1 ? AW-1 : 0:0] clr;
  logic signed [15:0] bsum;
  assign bsum = sat16(21'(newq) + 21'(amt));

  always_comb begin
    raddr_a = '0; raddr_b = '0;
    we = 1'b0; wpage = pg; waddr = pix; wdata = '0;
    stat.done = 1'b0;
    case (op)
      OP_CLEAR: begin
        we = 1'b1; waddr = clr[AW-1:0];
        stat.done = (clr[AW-1:0] == AW'(CELLS - 1)) && wpage;
      end
      OP_READ: begin
        raddr_a = AW'(ridx); raddr_b = AW'(ridx);
        stat.done = 1'b1;
      end
      OP_RIP: begin
        raddr_a = (ph == 4'd8) ? pix : nb;
        raddr_b = raddr_a;
        if (ph == 4'd8) begin raddr_a = pix; raddr_b = pix; end
        we = (ph == 4'd11);
        wdata = sat16(hd);
        stat.done = we && (cx == XLAST) && (cy == YLAST);
      end
      OP_BLOB: begin
        raddr_a = baddr; raddr_b = baddr;
        we = (ph == 4'd2) && bin;
        waddr = baddr; wdata = bsum;
        stat.done = (ph == 4'd2) && (dx == 5'(rad)) &&
                    (dy == 5'(rad));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_NONE; ph <= '0;
    end else begin
      if (cmd.first) begin
        op <= cmd.op; pg <= cmd.page; ph <= '0;
        cx <= XW'(1); cy <= YW'(1); clr <= '0;
        org_x <= pos_x; rad <= blob_radius; amt <= blob_height; ridx <= read_index;
        dx <= -$signed(5'(blob_radius)); dy <= -$signed(5'(blob_radius));
        bx <= 12'(pos_x) - 12'(blob_radius); by <= 12'(pos_y) - 12'(blob_radius);
        acc <= '0;
        if (cmd.op == OP_CLEAR) pg <= 1'b0;
      end else if (stat.done) begin
        op <= OP_NONE;
      end else begin
        case (op)
          OP_CLEAR: begin
            if (clr[AW-1:0] == AW'(CELLS - 1)) begin clr <= '0; pg <= 1'b1; end
            else clr <= clr + 1'b1;
          end
          OP_RIP: begin
            // reads issued ph0..8, data back in the following cycle
            if (ph >= 4'd1 && ph <= 4'd8) acc <= acc + 21'(oldq);
            if (ph == 4'd9) own <= newq;
            if (ph == 4'd11) begin
              ph <= '0; acc <= '0;
              if (cx == XLAST) begin cx <= XW'(1); cy <= cy + 1'b1; end
              else cx <= cx + 1'b1;
            end else ph <= ph + 1'b1;
          end
          OP_BLOB: begin
            if (ph == 4'd2) begin
              ph <= '0;
              if (dx == 5'(rad)) begin
                dx <= -$signed(5'(rad)); bx <= 12'(org_x) - 12'(rad);
                dy <= dy + 1'b1; by <= by + 1'b1;
              end else begin
                dx <= dx + 1'b1; bx <= bx + 1'b1;
              end
            end else ph <= ph + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign rd_value = pg ? q_b : q_a;

endmodule

// ----- rtl/wrh_ctrl.sv -----
// ----------------------------------------------------------------------------
// wrh_ctrl: command sequencer
// Clears memories after reset, accepts requests, sequences operations, and
// strobes the single result per request.
// ----------------------------------------------------------------------------
module wrh_ctrl import wrh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd_in,
  input  logic       read_page,
  input  logic       idx_ok,
  input  wrh_stat_t  stat,
  output wrh_cmd_t   cmd,
  output logic       busy,
  output logic       done,
  output logic       is_read_answer,
  output logic       zero_val
);

  localparam logic [2:0] S_INIT = 3'd0, S_CLR = 3'd1, S_IDLE = 3'd2,
                         S_RUN = 3'd3, S_RD = 3'd4, S_FIN = 3'd5;

  logic [2:0] state, state_next;
  logic       wpage, rdok, is_tick;

  always_comb begin
    state_next = state;
    cmd = '{op: OP_NONE, page: wpage, first: 1'b0};
    case (state)
      S_INIT: begin
        cmd = '{op: OP_CLEAR, page: 1'b0, first: 1'b1};
        state_next = S_CLR;
      end
      S_CLR: if (stat.done) state_next = S_IDLE;
      S_IDLE: if (start) begin
        case (cmd_in)
          CMD_TICK: begin cmd = '{op: OP_RIP, page: wpage, first: 1'b1};
                    state_next = S_RUN; end
          CMD_BLOB: begin cmd = '{op: OP_BLOB, page: wpage, first: 1'b1};
                    state_next = S_RUN; end
          CMD_READ: begin cmd = '{op: OP_READ, page: read_page, first: 1'b1};
                    state_next = S_RD; end
          default:  state_next = S_FIN;
        endcase
      end
      S_RUN: if (stat.done) state_next = S_FIN;
      S_RD:  state_next = S_FIN;
      S_FIN: state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; wpage <= 1'b0; rdok <= 1'b0; is_tick <= 1'b0;
      done <= 1'b0; is_read_answer <= 1'b0; zero_val <= 1'b1;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (state == S_IDLE && start) begin
        is_read_answer <= (cmd_in == CMD_READ);
        rdok <= idx_ok;
        is_tick <= (cmd_in == CMD_TICK);
      end
      if (state_next == S_FIN) begin
        done <= 1'b1;
        zero_val <= !(is_read_answer && rdok) || state != S_RD;
        if (state == S_IDLE) begin
          zero_val <= 1'b1; is_read_answer <= 1'b0;
        end
        if (state == S_RUN && is_tick) wpage <= !wpage;
      end
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- rtl/water_ripple_height_field_top.sv -----
// ----------------------------------------------------------------------------
// water_ripple_height_field_top: two page ripple height field
// ----------------------------------------------------------------------------
// Usage: raise start with cmd and the payload while busy is low. Each request
// gives exactly one result, shown on height_value / is_read_answer for one
// cycle with done high; the receiver cannot stall it.
// A blob walks the (2r+1)^2 square around pos_x / pos_y; a tick walks every
// interior pixel, bounded by the single read port per page: nine reads per
// interior pixel.
// Requests are taken one at a time; busy is high while one is in progress.
// Reset: both pages are cleared, one pass over all FIELD_WIDTH*FIELD_HEIGHT
// cells per page, with busy high; damping_shift writes are taken
// at any time through cfg_we / cfg_data and the reset value is 5.
// ----------------------------------------------------------------------------
module water_ripple_height_field_top import wrh_pkg::*; #(
  parameter int FIELD_WIDTH  = DEF_FIELD_WIDTH,
  parameter int FIELD_HEIGHT = DEF_FIELD_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic [3:0]         blob_radius,
  input  logic signed [15:0] blob_height,
  input  logic [13:0]        read_index,
  input  logic               read_page,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  output logic               done,
  output logic signed [15:0] height_value,
  output logic               is_read_answer
);

  logic [3:0] damping_shift;
  always_ff @(posedge clk) begin
    if (rst) damping_shift <= DAMP_RESET;
    else if (cfg_we) damping_shift <= cfg_data;
  end

  wrh_cmd_t  dcmd;
  wrh_stat_t stat;
  logic signed [15:0] rd_value;
  logic zero_val;

  wrh_ctrl u_ctrl (
    .clk, .rst, .start, .cmd_in(cmd), .read_page,
    .idx_ok(32'(read_index) < FIELD_WIDTH * FIELD_HEIGHT),
    .stat, .cmd(dcmd), .busy, .done, .is_read_answer, .zero_val
  );

  wrh_datapath #(.FIELD_WIDTH(FIELD_WIDTH), .FIELD_HEIGHT(FIELD_HEIGHT)) u_dp (
    .clk, .rst, .cmd(dcmd), .stat, .damp(damping_shift),
    .pos_x, .pos_y, .blob_radius, .blob_height, .read_index, .rd_value
  );

  // read data comes out of the memory register in the final cycle
  assign height_value = zero_val ? 16'sd0 : rd_value;

endmodule

// ----- rtl/wrh_checker.sv -----
// ----------------------------------------------------------------------------
// wrh_checker: port level checks for the ripple height field
// Watches the request and result strobes.
// ----------------------------------------------------------------------------
module wrh_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] height_value,
  input logic               is_read_answer
);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");

  a_zero_nonread: assert property (@(posedge clk) disable iff (rst)
    (done && !is_read_answer) |-> (height_value == 16'sd0))
    else $error("nonzero value without read");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after result");

endmodule

bind water_ripple_height_field_top wrh_checker u_chk (
  .clk, .rst, .start, .busy, .done, .height_value, .is_read_answer
);
